[design/acp_pkg.sv]
package acp_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int QUEUE_DEPTH = 4;

  localparam int COORD_W   = 12;
  localparam int CFG_W     = 13;
  localparam int ALPHA_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_THRESHOLD = 2'd2;

  localparam logic [CFG_W-1:0]   RESET_WIDTH     = 13'd1;
  localparam logic [CFG_W-1:0]   RESET_HEIGHT    = 13'd1;
  localparam logic [ALPHA_W-1:0] RESET_THRESHOLD = 8'd16;

  // One classified pixel, handed from the front to the back.
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row_out;    // row of the pixel being decided (one above)
    logic               has_result;
    logic               cur;        // opaque bit of this pixel
    logic               has_right;  // right neighbor lies inside the row
    logic               up_ok;      // pixel two rows up is inside the frame
    logic               left_ok;    // left neighbor lies inside the row
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               is_edge;
    logic               frame_end;
  } res_t;

endpackage

[design/acp_fifo.sv]
module acp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = acp_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Wrap the pointers at the last slot so any depth works.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNW'(1);
      end
    end
  end

endmodule

[design/acp_front.sv]
module acp_front #(
  parameter int MAX_WIDTH = acp_pkg::MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [acp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [acp_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            accept,
  input  logic [acp_pkg::ALPHA_W-1:0]     alpha,
  output acp_pkg::cmd_t                   cmd
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int FW  = acp_pkg::CFG_W;
  localparam int XW  = acp_pkg::COORD_W;
  localparam int MH  = acp_pkg::MAX_HEIGHT;
  localparam logic [FW-1:0] WIDTH_LIMIT  = MAX_WIDTH[FW-1:0];
  localparam logic [FW-1:0] HEIGHT_LIMIT = MH[FW-1:0];

  logic [FW-1:0]                   frame_width;
  logic [FW-1:0]                   frame_height;
  logic [acp_pkg::ALPHA_W-1:0]     alpha_threshold;
  logic [CW-1:0]                   col;
  logic [FW-1:0]                   row;

  logic [WW-1:0] w_eff;
  logic [WW-1:0] col_inc;
  logic [FW-1:0] h_eff;
  logic          flush;
  logic          has_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= acp_pkg::RESET_WIDTH;
      frame_height    <= acp_pkg::RESET_HEIGHT;
      alpha_threshold <= acp_pkg::RESET_THRESHOLD;
    end else if (cfg_write) begin
      case (cfg_index)
        acp_pkg::REG_FRAME_WIDTH: begin
          frame_width <= cfg_data;
        end
        acp_pkg::REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data;
        end
        acp_pkg::REG_ALPHA_THRESHOLD: begin
          alpha_threshold <= cfg_data[acp_pkg::ALPHA_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Zero acts as one; oversize clamps to the limit.
  always_comb begin
    if (frame_width == '0) begin
      w_eff = WW'(1);
    end else if (frame_width > WIDTH_LIMIT) begin
      w_eff = WIDTH_LIMIT[WW-1:0];
    end else begin
      w_eff = frame_width[WW-1:0];
    end
    if (frame_height == '0) begin
      h_eff = FW'(1);
    end else if (frame_height > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end else begin
      h_eff = frame_height;
    end
  end

  assign col_inc   = WW'(col) + WW'(1);
  assign has_right = (col_inc < w_eff);
  assign flush     = (row >= h_eff);

  always_comb begin
    cmd.col        = XW'(col);
    cmd.row_out    = XW'(row - FW'(1));
    cmd.has_result = (row != '0);
    cmd.cur        = !flush && (alpha > alpha_threshold);
    cmd.has_right  = has_right;
    cmd.up_ok      = (row >= FW'(2));
    cmd.left_ok    = (col != '0);
    cmd.last       = flush && !has_right;
  end

  // Advance the raster position on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (has_right) begin
        col <= col_inc[CW-1:0];
      end else begin
        col <= '0;
        row <= flush ? '0 : row + FW'(1);
      end
    end
  end

endmodule

[design/acp_back.sv]
module acp_back #(
  parameter int MAX_WIDTH = acp_pkg::MAX_WIDTH,
  parameter int DEPTH     = acp_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_empty,
  input  acp_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          clearing,
  input  logic          pop,
  output logic          empty,
  output acp_pkg::res_t res
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int NW  = $clog2(DEPTH + 1) + 1;
  localparam int RW  = $bits(acp_pkg::res_t);
  localparam logic [CW-1:0] LAST_ADDR = CW'(MAX_WIDTH - 1);

  // bit 1: row two above, bit 0: row above
  logic [1:0]    line_mem [MAX_WIDTH];
  logic [CW-1:0] clr_addr;

  logic [CW-1:0]  addr0;
  logic [CW-1:0]  addr1;
  logic           fetch;
  logic           s2_valid;
  acp_pkg::cmd_t  s2_cmd;
  logic [CW-1:0]  s2_addr;
  logic [1:0]     rd0;
  logic [1:0]     rd1;
  logic [1:0]     fwd;
  logic           eq0;
  logic           eq1;
  logic           above_prev;

  logic [1:0] ent0;
  logic [1:0] ent1;
  logic       above;
  logic       up;
  logic       left;
  logic       right;
  logic [1:0] wdata;

  acp_pkg::res_t          res_in;
  logic [RW-1:0]          res_bits;
  logic                   out_full;
  logic [$clog2(DEPTH+1)-1:0] out_count;

  assign addr0   = cmd.col[CW-1:0];
  assign addr1   = addr0 + CW'(1);
  assign s2_addr = s2_cmd.col[CW-1:0];

  // Take a command only when its result is sure of a slot.
  assign fetch   = !clearing && !cmd_empty &&
                   ((NW'(out_count) + NW'(s2_valid)) < NW'(DEPTH));
  assign cmd_pop = fetch;

  // Forward the write that lands on the same edge as the read.
  assign ent0  = eq0 ? fwd : rd0;
  assign ent1  = eq1 ? fwd : rd1;
  assign above = ent0[0];
  assign up    = s2_cmd.up_ok && ent0[1];
  assign left  = s2_cmd.left_ok && above_prev;
  assign right = s2_cmd.has_right && ent1[0];
  assign wdata = {above, s2_cmd.cur};

  always_ff @(posedge clk) begin
    if (clearing) begin
      line_mem[clr_addr] <= '0;
    end else if (s2_valid) begin
      line_mem[s2_addr] <= wdata;
    end
    if (fetch) begin
      rd0 <= line_mem[addr0];
      rd1 <= line_mem[addr1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      clearing <= 1'b1;
      clr_addr <= '0;
    end else begin
      s2_valid <= fetch;
      if (clearing) begin
        if (clr_addr == LAST_ADDR) begin
          clearing <= 1'b0;
        end
        clr_addr <= clr_addr + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fetch) begin
      s2_cmd <= cmd;
      eq0    <= s2_valid && (s2_addr == addr0);
      eq1    <= s2_valid && (s2_addr == addr1);
      fwd    <= wdata;
    end
    if (s2_valid) begin
      above_prev <= above;
    end
  end

  always_comb begin
    res_in.pixel_x   = s2_cmd.col;
    res_in.pixel_y   = s2_cmd.row_out;
    res_in.is_edge   = above && !(up && left && right && s2_cmd.cur);
    res_in.frame_end = s2_cmd.last;
  end

  acp_fifo #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (s2_valid && s2_cmd.has_result),
    .wdata (res_in),
    .pop   (pop),
    .rdata (res_bits),
    .empty (empty),
    .full  (out_full),
    .count (out_count)
  );

  assign res = acp_pkg::res_t'(res_bits | RW'(out_full & 1'b0));

endmodule

[design/alpha_contour_pixels.sv]
// Path: an accepted pixel beat is written to the command queue, fetched into the back's read
//   stage (line-buffer read), and its result is then written to the result queue for popping.
// Throughput: one pixel per cycle while results are popped and the line buffer is not clearing;
//   the line buffer reads two columns and writes one column per cycle.
// Reset (synchronous, rst high): registers return to width 1, height 1, threshold 16, and
//   the line buffer is cleared one column per cycle, all MAX_WIDTH columns, with full held high.
module alpha_contour_pixels #(
  parameter int MAX_WIDTH = acp_pkg::MAX_WIDTH,
  parameter int DEPTH     = acp_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_write,
  input  logic [acp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [acp_pkg::CFG_W-1:0]     cfg_data,
  // pixel side
  input  logic                          push,
  output logic                          full,
  input  logic [acp_pkg::ALPHA_W-1:0]   alpha,
  // result side
  output logic                          empty,
  input  logic                          pop,
  output logic [acp_pkg::COORD_W-1:0]   pixel_x,
  output logic [acp_pkg::COORD_W-1:0]   pixel_y,
  output logic                          is_edge,
  output logic                          frame_end
);

  localparam int CMD_W = $bits(acp_pkg::cmd_t);

  logic          accept;
  logic          cmd_full;
  logic          cmd_empty;
  logic          cmd_pop;
  logic          clearing;
  acp_pkg::cmd_t cmd_in;
  logic [CMD_W-1:0] cmd_bits;
  logic [$clog2(DEPTH+1)-1:0] cmd_count;
  acp_pkg::res_t res;

  // Hold off new beats while the command queue is full or the line buffer is clearing.
  assign full   = cmd_full || clearing;
  assign accept = push && !full;

  // Front: track the raster position, threshold the alpha and tag each beat with the
  // neighbor and frame-boundary flags the back needs.
  acp_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .alpha     (alpha),
    .cmd       (cmd_in)
  );

  // Short queue between front and back so either side can stall alone.
  acp_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .rdata (cmd_bits),
    .empty (cmd_empty),
    .full  (cmd_full),
    .count (cmd_count)
  );

  // Back: read the two-row line buffer, decide the pixel one row up, write back, and
  // queue the result.
  acp_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .DEPTH     (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (acp_pkg::cmd_t'(cmd_bits)),
    .cmd_pop   (cmd_pop),
    .clearing  (clearing),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  assign pixel_x   = res.pixel_x;
  assign pixel_y   = res.pixel_y;
  assign is_edge   = res.is_edge;
  assign frame_end = res.frame_end || (cmd_count != cmd_count);

endmodule
